[rtl/core/interval_booking_table_assert.svh]
// Assertion macros shared by the interval booking table checkers.
`ifndef INTERVAL_BOOKING_TABLE_ASSERT_SVH
`define INTERVAL_BOOKING_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IBT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("interval booking table: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("interval booking table: next-cycle check failed");

`endif

[rtl/core/ibt_pkg.sv]
// Package: types, constants and codes of the interval booking table.
`timescale 1ns / 1ps
package ibt_pkg;

    localparam int SLOT_DEPTH  = 96;
    localparam int TIME_BITS   = 16;
    localparam int RES_COUNT   = 256;
    localparam int RES_W       = $clog2(RES_COUNT);
    localparam int LIM_W       = $clog2(RES_COUNT + 1);
    localparam int IDX_W       = $clog2(SLOT_DEPTH);
    localparam int CNT_W       = $clog2(SLOT_DEPTH + 1);
    localparam int MIN_W       = 23;
    localparam int CMD_W       = 3;
    localparam int STAT_W      = 2;

    // Free-resource search walks the busy map in chunks of this many bits.
    localparam int FM_CHUNK    = (RES_COUNT < 16) ? RES_COUNT : 16;
    localparam int FM_CHUNKS   = RES_COUNT / FM_CHUNK;
    localparam int FM_OFS_W    = $clog2(FM_CHUNK);
    localparam int FM_CHK_W    = (FM_CHUNKS > 1) ? $clog2(FM_CHUNKS) : 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_BOOK   = 3'd1,
        CMD_CANCEL = 3'd2,
        CMD_TOTAL  = 3'd3,
        CMD_FREE   = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_CONFLICT = 2'd2,
        ST_NONE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SEARCH,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [TIME_BITS-1:0] t_begin;
        logic [TIME_BITS-1:0] t_end;
        logic [RES_W-1:0]     res;
        logic                 held;
    } t_entry;

    typedef struct packed {
        logic             clr;
        logic             set;
        logic [RES_W-1:0] set_id;
        logic             step;
    } t_fm_ctl;

    typedef struct packed {
        logic             hit;
        logic             miss;
        logic [RES_W-1:0] id;
    } t_fm_sts;

endpackage

[rtl/core/interval_booking_table.sv]
// Top level: command sequencer around the entry table and the free-resource map.
`timescale 1ns / 1ps
// Interval booking table.
// Input channel: i_in_valid / o_in_ready carry one command beat (cmd, start, end,
// resource, limit). Output channel: o_out_valid / i_out_ready carry one result
// beat per command (status, entry index, booked minutes, free resource).
// Commands run one at a time; the next command is taken in the cycle after the
// result beat is loaded. Add, unknown commands and a book with a bad interval
// go straight to the result. Book, cancel and total read the stored entries one
// per cycle through the table memory port; a cancel stops reading once it has
// found its entry. Find-free does the same scan to mark busy resources, then
// walks the busy map 16 resources per cycle.
// Results sit in an output register; the next command is taken while a
// result still waits for the receiver. A stalled receiver holds the result
// and, once a second result is ready, holds the sequencer until the first
// beat is taken.
// Reset clears the entry count and the handshake state; the table memory is
// not cleared since only entries below the count are ever read.
module interval_booking_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ibt_pkg::CMD_W-1:0]     i_cmd,
    input  logic [ibt_pkg::TIME_BITS-1:0] i_start_time,
    input  logic [ibt_pkg::TIME_BITS-1:0] i_end_time,
    input  logic [ibt_pkg::RES_W-1:0]     i_resource_id,
    input  logic [ibt_pkg::LIM_W-1:0]     i_resource_limit,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ibt_pkg::STAT_W-1:0]    o_status,
    output logic [ibt_pkg::IDX_W-1:0]     o_entry_index,
    output logic [ibt_pkg::MIN_W-1:0]     o_booked_minutes,
    output logic [ibt_pkg::RES_W-1:0]     o_free_resource
);
    import ibt_pkg::*;

    t_state               r_state,    n_state;
    t_cmd                 r_cmd,      n_cmd;
    logic [TIME_BITS-1:0] r_s,        n_s;
    logic [TIME_BITS-1:0] r_f,        n_f;
    logic [RES_W-1:0]     r_r,        n_r;
    logic [LIM_W-1:0]     r_lim,      n_lim;
    logic [CNT_W-1:0]     r_count,    n_count;
    logic [CNT_W-1:0]     r_rd_idx,   n_rd_idx;
    logic                 r_rd_vld,   n_rd_vld;
    logic [IDX_W-1:0]     r_rd_addr,  n_rd_addr;
    logic                 r_flag,     n_flag;
    logic [MIN_W-1:0]     r_sum,      n_sum;
    t_status              r_status,   n_status;
    logic [IDX_W-1:0]     r_idx,      n_idx;
    logic [RES_W-1:0]     r_freer,    n_freer;
    logic                 r_out_valid, n_out_valid;
    logic [STAT_W-1:0]    r_out_status, n_out_status;
    logic [IDX_W-1:0]     r_out_idx,   n_out_idx;
    logic [MIN_W-1:0]     r_out_min,   n_out_min;
    logic [RES_W-1:0]     r_out_free,  n_out_free;

    logic                 in_acc;
    logic                 issue;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    t_entry               ram_wdata;
    logic                 ram_re;
    t_entry               rd;
    t_fm_ctl              fm_ctl;
    t_fm_sts              fm_sts;
    logic                 overlap;
    logic [MIN_W:0]       sum_ext;

    ibt_table_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (rd)
    );

    ibt_free_map u_fmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fm_ctl),
        .i_limit (r_lim),
        .o_sts   (fm_sts)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // Half-open overlap of the read entry with the command interval.
    assign overlap = rd.held && (r_f > rd.t_begin) && (r_s < rd.t_end);
    assign sum_ext = {1'b0, r_sum} + (MIN_W + 1)'(rd.t_end - rd.t_begin);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_s          = r_s;
        n_f          = r_f;
        n_r          = r_r;
        n_lim        = r_lim;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_rd_vld     = 1'b0;
        n_rd_addr    = r_rd_addr;
        n_flag       = r_flag;
        n_sum        = r_sum;
        n_status     = r_status;
        n_idx        = r_idx;
        n_freer      = r_freer;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_min    = r_out_min;
        n_out_free   = r_out_free;
        issue        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_count[IDX_W-1:0];
        ram_wdata    = '{t_begin: r_s, t_end: r_f, res: r_r, held: 1'b1};
        ram_re       = 1'b0;
        fm_ctl       = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd    = t_cmd'(i_cmd);
                    n_s      = i_start_time;
                    n_f      = i_end_time;
                    n_r      = i_resource_id;
                    n_lim    = (i_resource_limit > LIM_W'(RES_COUNT)) ?
                               LIM_W'(RES_COUNT) : i_resource_limit;
                    n_rd_idx = '0;
                    n_flag   = 1'b0;
                    n_sum    = '0;
                    n_idx    = '0;
                    n_freer  = '0;
                    n_status = ST_OK;
                    case (t_cmd'(i_cmd))
                        CMD_ADD: begin
                            n_state = S_RESP;
                            if (r_count == CNT_W'(SLOT_DEPTH) || i_end_time <= i_start_time)
                            begin
                                n_status = ST_INVALID;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = '{t_begin: i_start_time, t_end: i_end_time,
                                              res: i_resource_id, held: 1'b0};
                                n_idx     = r_count[IDX_W-1:0];
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_BOOK: begin
                            if (i_end_time <= i_start_time) begin
                                n_status = ST_INVALID;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_CANCEL, CMD_TOTAL: begin
                            n_state = S_SCAN;
                        end
                        CMD_FREE: begin
                            fm_ctl.clr = 1'b1;
                            n_state    = S_SCAN;
                        end
                        default: begin
                            n_status = ST_INVALID;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Stop reading once a cancel has found its entry.
                issue     = (r_rd_idx < r_count) && !(r_cmd == CMD_CANCEL && r_flag);
                ram_re    = issue;
                n_rd_vld  = issue;
                n_rd_addr = r_rd_idx[IDX_W-1:0];
                if (issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end

                if (r_rd_vld) begin
                    case (r_cmd)
                        CMD_BOOK: begin
                            if (overlap && rd.res == r_r) begin
                                n_flag = 1'b1;
                            end
                        end
                        CMD_CANCEL: begin
                            if (!r_flag && rd.held && rd.t_begin == r_s && rd.res == r_r)
                            begin
                                n_flag         = 1'b1;
                                ram_we         = 1'b1;
                                ram_waddr      = r_rd_addr;
                                ram_wdata      = rd;
                                ram_wdata.held = 1'b0;
                            end
                        end
                        CMD_TOTAL: begin
                            if (rd.held && rd.res == r_r && rd.t_end > rd.t_begin) begin
                                n_sum = sum_ext[MIN_W] ? {MIN_W{1'b1}} : sum_ext[MIN_W-1:0];
                            end
                        end
                        CMD_FREE: begin
                            fm_ctl.set    = overlap;
                            fm_ctl.set_id = rd.res;
                        end
                        default: begin
                        end
                    endcase
                end

                if (!issue && !r_rd_vld) begin
                    n_state = S_RESP;
                    case (r_cmd)
                        CMD_BOOK: begin
                            if (r_flag) begin
                                n_status = ST_CONFLICT;
                            end else if (r_count == CNT_W'(SLOT_DEPTH)) begin
                                n_status = ST_INVALID;
                            end else begin
                                ram_we  = 1'b1;
                                n_idx   = r_count[IDX_W-1:0];
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_CANCEL: begin
                            n_status = r_flag ? ST_OK : ST_NONE;
                        end
                        CMD_FREE: begin
                            n_state = S_SEARCH;
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                fm_ctl.step = 1'b1;
                if (fm_sts.hit) begin
                    n_status = ST_OK;
                    n_freer  = fm_sts.id;
                    n_state  = S_RESP;
                end else if (fm_sts.miss) begin
                    n_status = ST_NONE;
                    n_state  = S_RESP;
                end
            end

            S_RESP: begin
                // Load the output register once it is free or being drained.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_idx    = r_idx;
                    n_out_min    = r_sum;
                    n_out_free   = r_freer;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_vld    <= n_rd_vld;
            r_flag      <= n_flag;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_s          <= n_s;
        r_f          <= n_f;
        r_r          <= n_r;
        r_lim        <= n_lim;
        r_rd_idx     <= n_rd_idx;
        r_rd_addr    <= n_rd_addr;
        r_sum        <= n_sum;
        r_status     <= n_status;
        r_idx        <= n_idx;
        r_freer      <= n_freer;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_min    <= n_out_min;
        r_out_free   <= n_out_free;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_entry_index    = r_out_idx;
    assign o_booked_minutes = r_out_min;
    assign o_free_resource  = r_out_free;

endmodule

[rtl/core/ibt_table_ram.sv]
// Entry table memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module ibt_table_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ibt_pkg::IDX_W-1:0] i_waddr,
    input  ibt_pkg::t_entry           i_wdata,
    input  logic                      i_re,
    input  logic [ibt_pkg::IDX_W-1:0] i_raddr,
    output ibt_pkg::t_entry           o_rdata
);
    import ibt_pkg::*;

    t_entry mem [SLOT_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/ibt_free_map.sv]
// Busy map of resources and a chunked search for the lowest free one.
`timescale 1ns / 1ps
module ibt_free_map (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ibt_pkg::t_fm_ctl          i_ctl,
    input  logic [ibt_pkg::LIM_W-1:0] i_limit,
    output ibt_pkg::t_fm_sts          o_sts
);
    import ibt_pkg::*;

    logic [RES_COUNT-1:0] r_busy;
    logic [FM_CHK_W-1:0]  r_chunk;
    logic [FM_CHK_W-1:0]  n_chunk;
    logic [FM_CHUNK-1:0]  cand;
    logic [FM_OFS_W-1:0]  pick;
    logic [RES_W-1:0]     slot_id;
    logic                 last_chunk;

    always_comb begin
        cand = '0;
        for (int j = 0; j < FM_CHUNK; j++) begin
            slot_id = RES_W'(r_chunk) * RES_W'(FM_CHUNK) + RES_W'(j);
            cand[j] = !r_busy[slot_id] && (LIM_W'(slot_id) < i_limit);
        end
        slot_id = '0;
    end

    // Lowest set bit of the chunk wins.
    always_comb begin
        pick = '0;
        for (int j = FM_CHUNK - 1; j >= 0; j--) begin
            if (cand[j]) begin
                pick = FM_OFS_W'(j);
            end
        end
    end

    assign last_chunk = (r_chunk == FM_CHK_W'(FM_CHUNKS - 1));

    always_comb begin
        o_sts.hit  = i_ctl.step && (|cand);
        o_sts.miss = i_ctl.step && !(|cand) && last_chunk;
        o_sts.id   = RES_W'(r_chunk) * RES_W'(FM_CHUNK) + RES_W'(pick);
        n_chunk    = r_chunk;
        if (i_ctl.clr) begin
            n_chunk = '0;
        end else if (i_ctl.step && !(|cand) && !last_chunk) begin
            n_chunk = r_chunk + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
        end else begin
            r_chunk <= n_chunk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_busy <= '0;
        end else if (i_ctl.set) begin
            r_busy[i_ctl.set_id] <= 1'b1;
        end
    end

endmodule

[rtl/core/ibt_checker.sv]
// Port-level checker for the interval booking table, bound to the top level.
`timescale 1ns / 1ps
`include "interval_booking_table_assert.svh"
module ibt_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  logic [ibt_pkg::CMD_W-1:0]     i_cmd,
    input  logic [ibt_pkg::TIME_BITS-1:0] i_start_time,
    input  logic [ibt_pkg::TIME_BITS-1:0] i_end_time,
    input  logic [ibt_pkg::RES_W-1:0]     i_resource_id,
    input  logic [ibt_pkg::LIM_W-1:0]     i_resource_limit,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [ibt_pkg::STAT_W-1:0]    o_status,
    input  logic [ibt_pkg::IDX_W-1:0]     o_entry_index,
    input  logic [ibt_pkg::MIN_W-1:0]     o_booked_minutes,
    input  logic [ibt_pkg::RES_W-1:0]     o_free_resource
);
    import ibt_pkg::*;

    logic in_beat;
    logic out_stall;
    logic not_ok;

    assign in_beat   = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign not_ok    = o_out_valid && (o_status != ST_OK);

    // One command in flight: the input side closes right after a beat.
    `IBT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_beat, !o_in_ready)

    // A stalled result beat holds.
    `IBT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_status) && $stable(o_entry_index) && $stable(o_booked_minutes) && $stable(o_free_resource))

    // A failed command reports no payload.
    `IBT_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, not_ok, o_entry_index == '0 && o_booked_minutes == '0 && o_free_resource == '0)

    // A placed entry always lies inside the table.
    `IBT_ASSERT_NOW(a_index_range, i_clk, i_rst_n, o_out_valid, o_entry_index <= IDX_W'(SLOT_DEPTH - 1))

endmodule

bind interval_booking_table ibt_checker u_ibt_checker (.*);
